FILE: rtl/mfd_pkg.sv
// ----------------------------------------------------------------------------
// mfd_pkg
// shared types and constants of the motor feedback frame decoder
// ----------------------------------------------------------------------------
package mfd_pkg;

  // number of motors on consecutive feedback identifiers (1 to 4)
  localparam int NUM_MOTORS = 4;
  localparam int MOTOR_W    = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

  // only four motors have an offset register, the rest use zero
  localparam int NUM_OFFSETS = 4;

  localparam int ID_W       = 11;
  localparam int OFFSET_W   = 13;
  localparam int ANGLE_W    = 16;
  localparam int TURNS_W    = 16;
  localparam int FRAMES_W   = 32;
  localparam int TICKS_W    = 30;
  localparam int TURN_SHIFT = 13;
  localparam int OUT_IDX_W  = 2;

  localparam logic [ID_W-1:0]    BASE_ID_RESET = 11'd517;
  localparam logic [ANGLE_W-1:0] HALF_TURN     = 16'd4096;
  localparam logic [ANGLE_W-1:0] NEG_HALF_TURN = 16'hF000;

  // configuration port
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_BASE_ID   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_M0 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_M1 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_M2 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_M3 = 3'd4;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [ID_W-1:0]                        base_id;
    logic [NUM_OFFSETS-1:0][OFFSET_W-1:0]   offset;
  } cfg_t;

  typedef struct packed {
    logic [MOTOR_W-1:0] motor;
    logic [ANGLE_W-1:0] angle;
    logic [15:0]        speed;
    logic [15:0]        torque;
    logic [7:0]         temp;
  } q_item_t;

  // angle offset of one motor, zero where no register exists
  function automatic logic [OFFSET_W-1:0] offset_of(input cfg_t cfg,
                                                    input logic [MOTOR_W-1:0] m);
    logic [OFFSET_W-1:0] res;
    res = '0;
    for (int i = 0; i < NUM_OFFSETS; i++) begin
      if (32'(m) == i) res = cfg.offset[i];
    end
    return res;
  endfunction

  function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [MOTOR_W-1:0] m);
    logic [7:0] wide;
    wide = 8'(m);
    return wide[OUT_IDX_W-1:0];
  endfunction

endpackage

FILE: rtl/mfd_regs.sv
// ----------------------------------------------------------------------------
// mfd_regs
// apb-style configuration registers: base identifier and angle offsets
// ----------------------------------------------------------------------------
module mfd_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mfd_pkg::ADDR_W-1:0]  paddr,
  input  logic [mfd_pkg::DATA_W-1:0]  pwdata,
  output logic [mfd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output mfd_pkg::cfg_t               cfg
);
  import mfd_pkg::*;

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_BASE_ID:   cfg_nxt.base_id   = pwdata[ID_W-1:0];
        REG_OFFSET_M0: cfg_nxt.offset[0] = pwdata[OFFSET_W-1:0];
        REG_OFFSET_M1: cfg_nxt.offset[1] = pwdata[OFFSET_W-1:0];
        REG_OFFSET_M2: cfg_nxt.offset[2] = pwdata[OFFSET_W-1:0];
        REG_OFFSET_M3: cfg_nxt.offset[3] = pwdata[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BASE_ID:   prdata = DATA_W'(cfg_r.base_id);
      REG_OFFSET_M0: prdata = DATA_W'(cfg_r.offset[0]);
      REG_OFFSET_M1: prdata = DATA_W'(cfg_r.offset[1]);
      REG_OFFSET_M2: prdata = DATA_W'(cfg_r.offset[2]);
      REG_OFFSET_M3: prdata = DATA_W'(cfg_r.offset[3]);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_id <= BASE_ID_RESET;
      cfg_r.offset  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/mfd_front.sv
// ----------------------------------------------------------------------------
// mfd_front
// accepts frames, matches the identifier and decodes the payload bytes
// ----------------------------------------------------------------------------
module mfd_front (
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [mfd_pkg::ID_W-1:0]  in_frame_id,
  input  logic [7:0]                in_byte0,
  input  logic [7:0]                in_byte1,
  input  logic [7:0]                in_byte2,
  input  logic [7:0]                in_byte3,
  input  logic [7:0]                in_byte4,
  input  logic [7:0]                in_byte5,
  input  logic [7:0]                in_byte6,
  input  logic [7:0]                in_byte7,
  input  mfd_pkg::cfg_t             cfg,
  input  logic                      q_full,
  output logic                      q_push,
  output mfd_pkg::q_item_t          q_item
);
  import mfd_pkg::*;

  logic [ID_W:0]       diff;
  logic                match;
  logic [MOTOR_W-1:0]  motor;
  logic [ANGLE_W-1:0]  raw;
  logic                unused_byte7;

  // borrow out of the subtraction means identifier below the base
  assign diff  = {1'b0, in_frame_id} - {1'b0, cfg.base_id};
  assign match = !diff[ID_W] && (diff[ID_W-1:0] < ID_W'(NUM_MOTORS));
  assign motor = diff[MOTOR_W-1:0];
  assign raw   = {in_byte0, in_byte1};

  assign unused_byte7 = ^in_byte7;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && match;

  always_comb begin
    q_item.motor  = motor;
    q_item.angle  = raw - ANGLE_W'(offset_of(cfg, motor));
    q_item.speed  = {in_byte2, in_byte3};
    q_item.torque = {in_byte4, in_byte5};
    q_item.temp   = in_byte6 ^ {8{unused_byte7 & 1'b0}};
  end

endmodule

FILE: rtl/mfd_queue.sv
// ----------------------------------------------------------------------------
// mfd_queue
// short first-in first-out queue of decoded frames
// ----------------------------------------------------------------------------
module mfd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mfd_pkg::q_item_t  push_item,
  input  logic              pop,
  output mfd_pkg::q_item_t  head,
  output logic              empty,
  output logic              full
);
  import mfd_pkg::*;

  q_item_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r;
  logic [QCNT_W-1:0]   count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/mfd_back.sv
// ----------------------------------------------------------------------------
// mfd_back
// per-motor turn tracking, frame counting and the output register
// ----------------------------------------------------------------------------
module mfd_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mfd_pkg::q_item_t                    head,
  input  logic                                q_empty,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mfd_pkg::OUT_IDX_W-1:0]       out_motor_index,
  output logic signed [mfd_pkg::ANGLE_W-1:0]  out_angle,
  output logic signed [15:0]                  out_speed,
  output logic signed [15:0]                  out_current,
  output logic [7:0]                          out_temperature,
  output logic signed [mfd_pkg::TURNS_W-1:0]  out_turns,
  output logic signed [mfd_pkg::TICKS_W-1:0]  out_ticks,
  output logic [mfd_pkg::FRAMES_W-1:0]        out_frame_count
);
  import mfd_pkg::*;

  logic [ANGLE_W-1:0]  last_angle_r [NUM_MOTORS];
  logic [TURNS_W-1:0]  turns_r      [NUM_MOTORS];
  logic [FRAMES_W-1:0] frames_r     [NUM_MOTORS];

  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [OUT_IDX_W-1:0] idx_r;
  logic [ANGLE_W-1:0]  angle_r;
  logic [15:0]         speed_r;
  logic [15:0]         torque_r;
  logic [7:0]          temp_r;
  logic [TURNS_W-1:0]  turns_out_r;
  logic [TICKS_W-1:0]  ticks_r;
  logic [FRAMES_W-1:0] frames_out_r;

  logic [ANGLE_W-1:0]  delta;
  logic                turn_dn;
  logic                turn_up;
  logic [TURNS_W-1:0]  turns_nxt;
  logic [TICKS_W-1:0]  ticks_nxt;
  logic [FRAMES_W-1:0] frames_nxt;

  // the output register frees up when it is empty or being taken
  assign q_pop = !q_empty && (!out_valid_r || !out_stall);

  // wrapped difference to the last angle of this motor
  assign delta   = head.angle - last_angle_r[head.motor];
  assign turn_dn = !delta[ANGLE_W-1] && (delta > HALF_TURN);
  assign turn_up = delta[ANGLE_W-1] && (delta < NEG_HALF_TURN);

  always_comb begin
    turns_nxt = turns_r[head.motor];
    if (turn_dn) begin
      turns_nxt = turns_r[head.motor] - 1'b1;
    end else if (turn_up) begin
      turns_nxt = turns_r[head.motor] + 1'b1;
    end
  end

  assign ticks_nxt  = {turns_nxt[TURNS_W-1], turns_nxt, {TURN_SHIFT{1'b0}}}
                    + {{(TICKS_W-ANGLE_W){head.angle[ANGLE_W-1]}}, head.angle};
  assign frames_nxt = frames_r[head.motor] + 1'b1;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_MOTORS; i++) begin
        last_angle_r[i] <= '0;
        turns_r[i]      <= '0;
        frames_r[i]     <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        last_angle_r[head.motor] <= head.angle;
        turns_r[head.motor]      <= turns_nxt;
        frames_r[head.motor]     <= frames_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      idx_r        <= to_out_idx(head.motor);
      angle_r      <= head.angle;
      speed_r      <= head.speed;
      torque_r     <= head.torque;
      temp_r       <= head.temp;
      turns_out_r  <= turns_nxt;
      ticks_r      <= ticks_nxt;
      frames_out_r <= frames_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_motor_index = idx_r;
  assign out_angle       = $signed(angle_r);
  assign out_speed       = $signed(speed_r);
  assign out_current     = $signed(torque_r);
  assign out_temperature = temp_r;
  assign out_turns       = $signed(turns_out_r);
  assign out_ticks       = $signed(ticks_r);
  assign out_frame_count = frames_out_r;

endmodule

FILE: rtl/motor_feedback_frame_decoder.sv
// ----------------------------------------------------------------------------
// motor_feedback_frame_decoder
// decodes motor feedback frames into angle, speed, current and turn tracking
// ----------------------------------------------------------------------------
// Takes one received standard frame per cycle (identifier plus eight bytes)
// unless the queue is full. Frames on one of the consecutive feedback
// identifiers starting at the base register are decoded for that motor; all
// other frames are taken and dropped without a result. The front matches and
// subtracts the offset into a two-entry queue; the back reads the motor's
// turn, angle and frame state, updates it and loads the output register.
// The sustained rate is one frame per clock while the output is not stalled,
// set by the single per-motor state update in the back; a stalled output
// holds the result while the queue keeps taking up to two more frames.
// Configuration sits on an apb-style port, registers at byte address four
// times the index: base identifier, then the four angle offsets.
module motor_feedback_frame_decoder (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mfd_pkg::ADDR_W-1:0]          paddr,
  input  logic [mfd_pkg::DATA_W-1:0]          pwdata,
  output logic [mfd_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  // frame requests
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mfd_pkg::ID_W-1:0]            in_frame_id,
  input  logic [7:0]                          in_byte0,
  input  logic [7:0]                          in_byte1,
  input  logic [7:0]                          in_byte2,
  input  logic [7:0]                          in_byte3,
  input  logic [7:0]                          in_byte4,
  input  logic [7:0]                          in_byte5,
  input  logic [7:0]                          in_byte6,
  input  logic [7:0]                          in_byte7,
  // decoded results
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mfd_pkg::OUT_IDX_W-1:0]       out_motor_index,
  output logic signed [mfd_pkg::ANGLE_W-1:0]  out_angle,
  output logic signed [15:0]                  out_speed,
  output logic signed [15:0]                  out_current,
  output logic [7:0]                          out_temperature,
  output logic signed [mfd_pkg::TURNS_W-1:0]  out_turns,
  output logic signed [mfd_pkg::TICKS_W-1:0]  out_ticks,
  output logic [mfd_pkg::FRAMES_W-1:0]        out_frame_count
);
  import mfd_pkg::*;

  cfg_t    cfg;
  q_item_t push_item;
  q_item_t head;
  logic    q_push;
  logic    q_pop;
  logic    q_empty;
  logic    q_full;

  // register file
  mfd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // identifier match and byte decode, pushes only matching frames
  mfd_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_frame_id (in_frame_id),
    .in_byte0    (in_byte0),
    .in_byte1    (in_byte1),
    .in_byte2    (in_byte2),
    .in_byte3    (in_byte3),
    .in_byte4    (in_byte4),
    .in_byte5    (in_byte5),
    .in_byte6    (in_byte6),
    .in_byte7    (in_byte7),
    .cfg         (cfg),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (push_item)
  );

  // decouples frame intake from a stalled output
  mfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // per-motor state and output register
  mfd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_motor_index (out_motor_index),
    .out_angle       (out_angle),
    .out_speed       (out_speed),
    .out_current     (out_current),
    .out_temperature (out_temperature),
    .out_turns       (out_turns),
    .out_ticks       (out_ticks),
    .out_frame_count (out_frame_count)
  );

  // the back never takes from an empty queue
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // an empty queue never holds off a new frame
  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> !in_stall)
    else $error("frame stalled with empty queue");

  // a result still waiting is never overwritten by a new pop
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> !q_pop)
    else $error("pending result overwritten");

  // every pop shows up as a valid result on the next cycle
  a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid)
    else $error("popped frame produced no result");

endmodule
